>>> rtl/wps_pkg.sv
// Shared types, constants and microprogram for the wheel pulse speedometer.
package wps_pkg;

    localparam int TIME_BITS_DEF = 32;

    localparam int DIAM_W     = 8;
    localparam int DEB_W      = 16;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;
    localparam int TIME_IN_W  = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_WHEEL_DIAMETER = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE_MS    = 1'd1;

    localparam logic [DIAM_W-1:0] DIAM_RESET = 8'd27;
    localparam logic [DEB_W-1:0]  DEB_RESET  = 16'd100;

    localparam int K_W     = 17;
    localparam int SPD_W   = 18;
    localparam int ACC_W   = 20;
    localparam int TRIP_W  = 32;
    localparam int TOTAL_W = 32;
    localparam int TP_W    = 40;
    localparam int TX_W    = 50;
    localparam int NUM_W   = 27;
    localparam int DVD_W   = 32;
    localparam int REM_W   = 25;
    localparam int CNT_W   = 5;
    localparam int PC_W    = 4;
    localparam int OP_W    = 4;

    localparam logic [8:0]  SPEED_FACTOR = 9'd287;
    localparam logic [8:0]  ACCEL_FACTOR = 9'd278;
    localparam logic [13:0] TRIP_DIVISOR = 14'd12547;

    localparam logic [SPD_W-1:0]         SPEED_MAX = 18'h3FFFF;
    localparam logic signed [ACC_W-1:0]  ACCEL_MAX = 20'sh7FFFF;
    localparam logic signed [ACC_W-1:0]  ACCEL_MIN = 20'sh80000;
    localparam logic [TRIP_W-1:0]        TRIP_MAX  = 32'hFFFF_FFFF;
    localparam logic [TX_W-1:0]          TRIP_SAT_LIMIT = TX_W'({TRIP_DIVISOR, 32'd0});
    localparam logic [DVD_W-1:0]         ACC_NEG_LIMIT  = 32'd524288;
    localparam logic [DVD_W-1:0]         ACC_POS_LIMIT  = 32'd524287;

    // two quotient bits per divider step
    localparam logic [CNT_W-1:0] SPD_STEPS  = 5'd13;
    localparam logic [CNT_W-1:0] ACC_STEPS  = 5'd14;
    localparam logic [CNT_W-1:0] TRIP_STEPS = 5'd16;

    localparam logic [OP_W-1:0] OP_IDLE      = 4'd0;
    localparam logic [OP_W-1:0] OP_UPDATE    = 4'd1;
    localparam logic [OP_W-1:0] OP_PREP      = 4'd2;
    localparam logic [OP_W-1:0] OP_TRIP_LOAD = 4'd3;
    localparam logic [OP_W-1:0] OP_DIV       = 4'd4;
    localparam logic [OP_W-1:0] OP_TRIP_SPD  = 4'd5;
    localparam logic [OP_W-1:0] OP_V0_Q      = 4'd6;
    localparam logic [OP_W-1:0] OP_V1        = 4'd7;
    localparam logic [OP_W-1:0] OP_ACC_LOAD  = 4'd8;
    localparam logic [OP_W-1:0] OP_FINISH    = 4'd9;

    localparam logic [1:0] H_NONE = 2'd0;
    localparam logic [1:0] H_IN   = 2'd1;
    localparam logic [1:0] H_DIV  = 2'd2;
    localparam logic [1:0] H_OUT  = 2'd3;

    localparam logic [1:0] J_NEXT   = 2'd0;
    localparam logic [1:0] J_ALWAYS = 2'd1;
    localparam logic [1:0] J_FIXED  = 2'd2;

    localparam logic [PC_W-1:0] PC_IDLE      = 4'd0;
    localparam logic [PC_W-1:0] PC_UPDATE    = 4'd1;
    localparam logic [PC_W-1:0] PC_PREP      = 4'd2;
    localparam logic [PC_W-1:0] PC_TRIP_LOAD = 4'd3;
    localparam logic [PC_W-1:0] PC_TRIP_DIV  = 4'd4;
    localparam logic [PC_W-1:0] PC_TRIP_SPD  = 4'd5;
    localparam logic [PC_W-1:0] PC_SPD_DIV   = 4'd6;
    localparam logic [PC_W-1:0] PC_V0_Q      = 4'd7;
    localparam logic [PC_W-1:0] PC_Q_DIV     = 4'd8;
    localparam logic [PC_W-1:0] PC_V1        = 4'd9;
    localparam logic [PC_W-1:0] PC_ACC_LOAD  = 4'd10;
    localparam logic [PC_W-1:0] PC_ACC_DIV   = 4'd11;
    localparam logic [PC_W-1:0] PC_FINISH    = 4'd12;

    typedef struct packed {
        logic                 command;
        logic [TIME_IN_W-1:0] time_ms;
    } t_in;

    typedef struct packed {
        logic                       pulse_accepted;
        logic [SPD_W-1:0]           speed_q8;
        logic signed [ACC_W-1:0]    accel_q8;
        logic [TRIP_W-1:0]          trip_m;
    } t_out;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic [1:0]      hold;
        logic [1:0]      jump;
        logic [PC_W-1:0] target;
    } t_uword;

    function automatic t_uword ucode(input logic [PC_W-1:0] pc);
        t_uword w;
        w = '{op: OP_IDLE, hold: H_IN, jump: J_NEXT, target: PC_IDLE};
        case (pc)
            PC_IDLE:      w = '{op: OP_IDLE,      hold: H_IN,   jump: J_NEXT,   target: PC_IDLE};
            PC_UPDATE:    w = '{op: OP_UPDATE,    hold: H_NONE, jump: J_NEXT,   target: PC_IDLE};
            PC_PREP:      w = '{op: OP_PREP,      hold: H_NONE, jump: J_NEXT,   target: PC_IDLE};
            PC_TRIP_LOAD: w = '{op: OP_TRIP_LOAD, hold: H_NONE, jump: J_NEXT,   target: PC_IDLE};
            PC_TRIP_DIV:  w = '{op: OP_DIV,       hold: H_DIV,  jump: J_NEXT,   target: PC_IDLE};
            PC_TRIP_SPD:  w = '{op: OP_TRIP_SPD,  hold: H_NONE, jump: J_FIXED,  target: PC_FINISH};
            PC_SPD_DIV:   w = '{op: OP_DIV,       hold: H_DIV,  jump: J_NEXT,   target: PC_IDLE};
            PC_V0_Q:      w = '{op: OP_V0_Q,      hold: H_NONE, jump: J_NEXT,   target: PC_IDLE};
            PC_Q_DIV:     w = '{op: OP_DIV,       hold: H_DIV,  jump: J_NEXT,   target: PC_IDLE};
            PC_V1:        w = '{op: OP_V1,        hold: H_NONE, jump: J_NEXT,   target: PC_IDLE};
            PC_ACC_LOAD:  w = '{op: OP_ACC_LOAD,  hold: H_NONE, jump: J_NEXT,   target: PC_IDLE};
            PC_ACC_DIV:   w = '{op: OP_DIV,       hold: H_DIV,  jump: J_NEXT,   target: PC_IDLE};
            PC_FINISH:    w = '{op: OP_FINISH,    hold: H_OUT,  jump: J_ALWAYS, target: PC_IDLE};
            default:      w = '{op: OP_IDLE,      hold: H_NONE, jump: J_ALWAYS, target: PC_IDLE};
        endcase
        return w;
    endfunction

endpackage

>>> rtl/wheel_pulse_speedometer.sv
// Wheel pulse speedometer: microcoded sequencer around a shared divider.
//
// Input channel (i_in_valid / o_in_stall / i_in_data): each transaction is a
// wheel pulse or a query with a millisecond timestamp. Output channel
// (o_out_valid / i_out_stall / o_out_data): one result per input transaction
// with pulse_accepted, speed, acceleration and trip distance.
// Configuration: i_cfg_we writes i_cfg_data into register i_cfg_idx
// (0 = wheel diameter, 1 = debounce time); write only while idle.
// An accepted transaction passes the update, prepare and trip division steps;
// the speed, previous speed and acceleration divisions follow unless speed is
// zero-period saturated or at or below 1 km/h. One transaction is in work at a
// time; the next can be taken in the cycle after the result is registered.
// The shared divider, two quotient bits a cycle, runs the trip, speed, previous
// speed and acceleration divisions in turn.
// A finished result waits in the output register; while the receiver stalls,
// the sequencer holds on its last step and accepts no input.
// Reset (synchronous, active low) restores diameter 27 and debounce 100 ms,
// clears the pulse history and count and empties the output register.
module wheel_pulse_speedometer #(
    parameter int TIME_BITS = wps_pkg::TIME_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  wps_pkg::t_in                       i_in_data,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output wps_pkg::t_out                      o_out_data,
    input  logic                               i_cfg_we,
    input  logic [wps_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [wps_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    localparam int WW = (TIME_BITS > wps_pkg::DVD_W) ? TIME_BITS : wps_pkg::DVD_W;

    logic [wps_pkg::PC_W-1:0]     r_pc, n_pc;
    logic [wps_pkg::CNT_W-1:0]    r_cnt, n_cnt;
    logic [TIME_BITS-1:0]         r_now, n_now;
    logic                         r_cmd, n_cmd;
    logic [TIME_BITS-1:0]         r_last, n_last;
    logic [TIME_BITS-1:0]         r_prev, n_prev;
    logic [TIME_BITS-1:0]         r_old, n_old;
    logic [wps_pkg::TOTAL_W-1:0]  r_total, n_total;
    logic                         r_acc, n_acc;
    logic [wps_pkg::DIAM_W-1:0]   r_diam, n_diam;
    logic [wps_pkg::DEB_W-1:0]    r_deb, n_deb;
    logic [wps_pkg::K_W-1:0]      r_k, n_k;
    logic [wps_pkg::K_W-1:0]      r_p, n_p;
    logic                         r_p_zero, n_p_zero;
    logic                         r_k_le_p, n_k_le_p;
    logic [wps_pkg::REM_W-1:0]    r_q, n_q;
    logic                         r_q_zero, n_q_zero;
    logic                         r_q_big, n_q_big;
    logic [wps_pkg::TP_W-1:0]     r_tp, n_tp;
    logic                         r_trip_sat, n_trip_sat;
    logic [wps_pkg::REM_W-1:0]    r_rem, n_rem;
    logic [wps_pkg::DVD_W-1:0]    r_dvd, n_dvd;
    logic [wps_pkg::REM_W-1:0]    r_dvs, n_dvs;
    logic [wps_pkg::TRIP_W-1:0]   r_trip, n_trip;
    logic [wps_pkg::SPD_W-1:0]    r_speed, n_speed;
    logic signed [wps_pkg::ACC_W-1:0] r_accel, n_accel;
    logic [wps_pkg::SPD_W-1:0]    r_v0, n_v0;
    logic [wps_pkg::SPD_W-1:0]    r_v1, n_v1;
    logic                         r_neg, n_neg;
    logic                         r_out_valid, n_out_valid;
    wps_pkg::t_out                r_out, n_out;

    wps_pkg::t_uword              uw;
    logic                         hold_c;
    logic                         adv;
    logic                         fixed;
    logic                         out_taken;

    logic [TIME_BITS-1:0]         since_u;
    logic [TIME_BITS-1:0]         per_p;
    logic [TIME_BITS-1:0]         since_p;
    logic [TIME_BITS-1:0]         p_max;
    logic [TIME_BITS-1:0]         q_t;
    logic [WW-1:0]                p_ext;
    logic [WW-1:0]                q_ext;
    logic [wps_pkg::K_W-1:0]      k_c;
    logic [wps_pkg::TX_W-1:0]     tx;
    logic [wps_pkg::SPD_W-1:0]    spd_q;
    logic [wps_pkg::SPD_W-1:0]    diff;
    logic [wps_pkg::NUM_W-1:0]    num;
    logic signed [wps_pkg::ACC_W-1:0] acc_q;

    logic [wps_pkg::REM_W:0]      t1, t2;
    logic                         ge1, ge2;
    logic [wps_pkg::REM_W-1:0]    rm1, rm2;

    assign uw         = wps_pkg::ucode(r_pc);
    assign fixed      = r_p_zero || r_k_le_p;
    assign out_taken  = r_out_valid && !i_out_stall;
    assign o_in_stall = (r_pc != wps_pkg::PC_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_comb begin
        case (uw.hold)
            wps_pkg::H_IN:  hold_c = !i_in_valid;
            wps_pkg::H_DIV: hold_c = (r_cnt != wps_pkg::CNT_W'(1));
            wps_pkg::H_OUT: hold_c = r_out_valid && i_out_stall;
            default:        hold_c = 1'b0;
        endcase
    end
    assign adv = !hold_c;

    // radix-4 restoring divide step
    always_comb begin
        t1  = {r_rem, r_dvd[wps_pkg::DVD_W-1]};
        ge1 = (t1 >= {1'b0, r_dvs});
        rm1 = ge1 ? wps_pkg::REM_W'(t1 - {1'b0, r_dvs}) : t1[wps_pkg::REM_W-1:0];
        t2  = {rm1, r_dvd[wps_pkg::DVD_W-2]};
        ge2 = (t2 >= {1'b0, r_dvs});
        rm2 = ge2 ? wps_pkg::REM_W'(t2 - {1'b0, r_dvs}) : t2[wps_pkg::REM_W-1:0];
    end

    always_comb begin
        since_u = r_now - r_last;
        per_p   = r_last - r_prev;
        since_p = r_now - r_last;
        p_max   = (since_p > per_p) ? since_p : per_p;
        q_t     = r_prev - r_old;
        p_ext   = WW'(p_max);
        q_ext   = WW'(q_t);
        k_c     = wps_pkg::K_W'(r_diam) * wps_pkg::K_W'(wps_pkg::SPEED_FACTOR);
        tx      = wps_pkg::TX_W'({r_tp, 10'd0}) - wps_pkg::TX_W'({r_tp, 5'd0})
                + wps_pkg::TX_W'({r_tp, 3'd0});
        spd_q   = (|r_dvd[wps_pkg::DVD_W-1:wps_pkg::SPD_W]) ? wps_pkg::SPEED_MAX
                                                             : r_dvd[wps_pkg::SPD_W-1:0];
        diff    = (r_v1 > r_v0) ? (r_v1 - r_v0) : (r_v0 - r_v1);
        num     = wps_pkg::NUM_W'(diff) * wps_pkg::NUM_W'(wps_pkg::ACCEL_FACTOR);
        if (fixed) begin
            acc_q = r_accel;
        end else if (r_neg) begin
            acc_q = (r_dvd > wps_pkg::ACC_NEG_LIMIT) ? wps_pkg::ACCEL_MIN
                    : wps_pkg::ACC_W'(wps_pkg::ACC_W'(0) - r_dvd[wps_pkg::ACC_W-1:0]);
        end else begin
            acc_q = (r_dvd > wps_pkg::ACC_POS_LIMIT) ? wps_pkg::ACCEL_MAX
                    : $signed(r_dvd[wps_pkg::ACC_W-1:0]);
        end
    end

    always_comb begin
        n_cnt = r_cnt;    n_now = r_now;     n_cmd = r_cmd;
        n_last = r_last;  n_prev = r_prev;   n_old = r_old;
        n_total = r_total; n_acc = r_acc;    n_diam = r_diam;
        n_deb = r_deb;    n_k = r_k;         n_p = r_p;
        n_p_zero = r_p_zero; n_k_le_p = r_k_le_p;
        n_q = r_q;        n_q_zero = r_q_zero; n_q_big = r_q_big;
        n_tp = r_tp;      n_trip_sat = r_trip_sat;
        n_rem = r_rem;    n_dvd = r_dvd;     n_dvs = r_dvs;
        n_trip = r_trip;  n_speed = r_speed; n_accel = r_accel;
        n_v0 = r_v0;      n_v1 = r_v1;       n_neg = r_neg;
        n_out = r_out;
        n_out_valid = r_out_valid && !out_taken;

        if (i_cfg_we) begin
            case (i_cfg_idx)
                wps_pkg::CFG_WHEEL_DIAMETER: n_diam = i_cfg_data[wps_pkg::DIAM_W-1:0];
                wps_pkg::CFG_DEBOUNCE_MS:    n_deb  = i_cfg_data[wps_pkg::DEB_W-1:0];
                default: ;
            endcase
        end

        case (uw.op)
            wps_pkg::OP_IDLE: begin
                if (adv) begin
                    n_now = TIME_BITS'(i_in_data.time_ms);
                    n_cmd = i_in_data.command;
                end
            end
            wps_pkg::OP_UPDATE: begin
                n_acc = 1'b0;
                if (!r_cmd && (since_u >= TIME_BITS'(r_deb))) begin
                    n_old   = r_prev;
                    n_prev  = r_last;
                    n_last  = r_now;
                    n_total = r_total + wps_pkg::TOTAL_W'(1);
                    n_acc   = 1'b1;
                end
            end
            wps_pkg::OP_PREP: begin
                n_k      = k_c;
                n_p      = p_ext[wps_pkg::K_W-1:0];
                n_p_zero = (p_ext == '0);
                n_k_le_p = (|p_ext[WW-1:wps_pkg::K_W]) || (k_c <= p_ext[wps_pkg::K_W-1:0]);
                n_q      = q_ext[wps_pkg::REM_W-1:0];
                n_q_zero = (q_ext == '0);
                n_q_big  = |q_ext[WW-1:wps_pkg::REM_W];
                n_tp     = wps_pkg::TP_W'(r_total) * wps_pkg::TP_W'(r_diam);
            end
            wps_pkg::OP_TRIP_LOAD: begin
                n_trip_sat = (tx >= wps_pkg::TRIP_SAT_LIMIT);
                n_rem = wps_pkg::REM_W'(tx[wps_pkg::TX_W-1:wps_pkg::DVD_W]);
                n_dvd = tx[wps_pkg::DVD_W-1:0];
                n_dvs = wps_pkg::REM_W'(wps_pkg::TRIP_DIVISOR);
                n_cnt = wps_pkg::TRIP_STEPS;
            end
            wps_pkg::OP_DIV: begin
                n_rem = rm2;
                n_dvd = {r_dvd[wps_pkg::DVD_W-3:0], ge1, ge2};
                n_cnt = r_cnt - wps_pkg::CNT_W'(1);
            end
            wps_pkg::OP_TRIP_SPD: begin
                n_trip  = r_trip_sat ? wps_pkg::TRIP_MAX : r_dvd;
                n_speed = r_p_zero ? wps_pkg::SPEED_MAX : '0;
                n_accel = r_p_zero ? wps_pkg::ACCEL_MAX : '0;
                n_rem   = '0;
                n_dvd   = {1'b0, r_k, 14'd0};
                n_dvs   = wps_pkg::REM_W'(r_p);
                n_cnt   = wps_pkg::SPD_STEPS;
            end
            wps_pkg::OP_V0_Q: begin
                n_speed = spd_q;
                n_v0    = spd_q;
                n_rem   = '0;
                n_dvd   = {1'b0, r_k, 14'd0};
                n_dvs   = r_q;
                n_cnt   = wps_pkg::SPD_STEPS;
            end
            wps_pkg::OP_V1: begin
                n_v1 = r_q_zero ? wps_pkg::SPEED_MAX : (r_q_big ? '0 : spd_q);
            end
            wps_pkg::OP_ACC_LOAD: begin
                n_neg = (r_v1 > r_v0);
                n_rem = '0;
                n_dvd = {1'b0, num, 4'd0};
                n_dvs = wps_pkg::REM_W'(r_p);
                n_cnt = wps_pkg::ACC_STEPS;
            end
            wps_pkg::OP_FINISH: begin
                if (adv) begin
                    n_out_valid = 1'b1;
                    n_out = '{pulse_accepted: r_acc, speed_q8: r_speed,
                              accel_q8: acc_q, trip_m: r_trip};
                end
            end
            default: ;
        endcase

        if (hold_c) begin
            n_pc = r_pc;
        end else begin
            case (uw.jump)
                wps_pkg::J_ALWAYS: n_pc = uw.target;
                wps_pkg::J_FIXED:  n_pc = fixed ? uw.target : wps_pkg::PC_W'(r_pc + 1'b1);
                default:           n_pc = wps_pkg::PC_W'(r_pc + 1'b1);
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc        <= wps_pkg::PC_IDLE;
            r_out_valid <= 1'b0;
            r_diam      <= wps_pkg::DIAM_RESET;
            r_deb       <= wps_pkg::DEB_RESET;
            r_last      <= '0;
            r_prev      <= '0;
            r_old       <= '0;
            r_total     <= '0;
            r_cnt       <= '0;
        end else begin
            r_pc        <= n_pc;
            r_out_valid <= n_out_valid;
            r_diam      <= n_diam;
            r_deb       <= n_deb;
            r_last      <= n_last;
            r_prev      <= n_prev;
            r_old       <= n_old;
            r_total     <= n_total;
            r_cnt       <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_now      <= n_now;
        r_cmd      <= n_cmd;
        r_acc      <= n_acc;
        r_k        <= n_k;
        r_p        <= n_p;
        r_p_zero   <= n_p_zero;
        r_k_le_p   <= n_k_le_p;
        r_q        <= n_q;
        r_q_zero   <= n_q_zero;
        r_q_big    <= n_q_big;
        r_tp       <= n_tp;
        r_trip_sat <= n_trip_sat;
        r_rem      <= n_rem;
        r_dvd      <= n_dvd;
        r_dvs      <= n_dvs;
        r_trip     <= n_trip;
        r_speed    <= n_speed;
        r_accel    <= n_accel;
        r_v0       <= n_v0;
        r_v1       <= n_v1;
        r_neg      <= n_neg;
        r_out      <= n_out;
    end

`ifndef ASSERT_OFF
    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> (r_pc == wps_pkg::PC_UPDATE))
        else $error("accepted transaction did not start the update step");

    a_div_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pc == wps_pkg::PC_TRIP_DIV || r_pc == wps_pkg::PC_SPD_DIV ||
         r_pc == wps_pkg::PC_Q_DIV || r_pc == wps_pkg::PC_ACC_DIV) |-> (r_cnt != '0))
        else $error("divider step count exhausted inside a divide step");

    a_short_path: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pc == wps_pkg::PC_SPD_DIV) |-> !(r_p_zero || r_k_le_p))
        else $error("speed division entered although speed is fixed");

    a_out_from_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && $rose(r_out_valid)) |-> ($past(r_pc) == wps_pkg::PC_FINISH))
        else $error("result registered outside the finish step");

    a_total_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && !$stable(r_total)) |->
        ($past(r_pc) == wps_pkg::PC_UPDATE && r_acc))
        else $error("pulse count changed without an accepted pulse");
`endif

endmodule

>>> bench/tb.sv
// Testbench for the wheel pulse speedometer: directed table, then randomised phases.
`timescale 1ns / 1ps

module tb;

    localparam logic CMD_PULSE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    localparam longint unsigned KMH_FACTOR   = 64'd287;
    localparam longint unsigned ACCEL_FACTOR = 64'd278;
    localparam longint unsigned TRIP_DIV     = 64'd12547;
    localparam longint unsigned SPEED_CEIL   = 64'd262143;

    localparam logic [17:0]        SPEED_TOP    = 18'h3FFFF;
    localparam logic signed [19:0] ACCEL_TOP    = 20'sh7FFFF;
    localparam logic signed [19:0] ACCEL_BOTTOM = 20'sh80000;

    localparam int QUIET_LIMIT  = 3000;
    localparam int SETTLE_WAIT  = 70;
    localparam int PHASES       = 8;
    localparam int PHASE_ITEMS  = 130;
    localparam int DIRECTED_LEN = 28;

    typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_e;

    typedef struct packed {
        row_kind_e                        kind;
        logic [wps_pkg::CFG_IDX_W-1:0]    idx;
        logic [wps_pkg::CFG_DATA_W-1:0]   val;
        logic                             cmd;
        logic [31:0]                      at_ms;
        logic                             checked;
        wps_pkg::t_out                    want;
    } script_row_t;

    logic                            i_clk;
    logic                            i_rst_n;
    logic                            i_in_valid;
    logic                            o_in_stall;
    wps_pkg::t_in                    i_in_data;
    logic                            o_out_valid;
    logic                            i_out_stall;
    wps_pkg::t_out                   o_out_data;
    logic                            i_cfg_we;
    logic [wps_pkg::CFG_IDX_W-1:0]   i_cfg_idx;
    logic [wps_pkg::CFG_DATA_W-1:0]  i_cfg_data;

    logic [7:0]  wheel_diam = 8'd27;
    logic [15:0] debounce_ms = 16'd100;
    logic [31:0] last_pulse = '0;
    logic [31:0] prev_pulse = '0;
    logic [31:0] oldest_pulse = '0;
    logic [31:0] pulse_count = '0;

    wps_pkg::t_out expected_readings [$];
    wps_pkg::t_out typed_reading;
    logic          use_typed;
    int            mismatch_count = 0;
    int            quiet_cycles = 0;

    script_row_t directed [DIRECTED_LEN];

    wheel_pulse_speedometer u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic longint unsigned speed_over(input longint unsigned k,
                                                   input longint unsigned d);
        longint unsigned v;
        if (d == 0) begin
            return SPEED_CEIL;
        end
        v = (k * 256) / d;
        return (v > SPEED_CEIL) ? SPEED_CEIL : v;
    endfunction

    function automatic wps_pkg::t_out predict_reading(input wps_pkg::t_in it);
        wps_pkg::t_out   r;
        logic [31:0]     now_ms;
        logic [31:0]     gap_ms;
        logic [31:0]     p;
        logic [31:0]     since;
        logic [31:0]     q;
        longint unsigned k;
        longint unsigned v0;
        longint unsigned v1;
        longint unsigned mag;
        longint unsigned trip;
        logic            took;
        logic            neg;
        now_ms = it.time_ms;
        gap_ms = now_ms - last_pulse;
        took = (it.command == CMD_PULSE) && (gap_ms >= {16'd0, debounce_ms});
        if (took) begin
            oldest_pulse = prev_pulse;
            prev_pulse   = last_pulse;
            last_pulse   = now_ms;
            pulse_count  = pulse_count + 32'd1;
        end
        k = 64'(wheel_diam) * KMH_FACTOR;
        p = last_pulse - prev_pulse;
        since = now_ms - last_pulse;
        if (since > p) begin
            p = since;
        end
        q = prev_pulse - oldest_pulse;
        r.pulse_accepted = took;
        if (p == 0) begin
            r.speed_q8 = SPEED_TOP;
            r.accel_q8 = ACCEL_TOP;
        end else if (k <= 64'(p)) begin
            r.speed_q8 = '0;
            r.accel_q8 = '0;
        end else begin
            v0 = speed_over(k, 64'(p));
            v1 = speed_over(k, 64'(q));
            neg = v1 > v0;
            mag = (ACCEL_FACTOR * (neg ? v1 - v0 : v0 - v1)) / 64'(p);
            r.speed_q8 = 18'(v0);
            if (neg) begin
                r.accel_q8 = (mag > 64'd524288) ? ACCEL_BOTTOM : 20'(64'd0 - mag);
            end else begin
                r.accel_q8 = (mag > 64'd524287) ? ACCEL_TOP : 20'(mag);
            end
        end
        trip = (64'(pulse_count) * 64'(wheel_diam) * 64'd1000) / TRIP_DIV;
        r.trip_m = (trip > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : trip[31:0];
        return r;
    endfunction

    always @(posedge i_clk) begin : monitor
        wps_pkg::t_out want;
        logic          out_taken;
        logic          in_taken;
        out_taken = o_out_valid && !i_out_stall;
        in_taken  = i_in_valid && !o_in_stall;
        if (i_rst_n) begin
            if (out_taken) begin
                if (expected_readings.size() == 0) begin
                    $error("result transaction with none outstanding");
                    mismatch_count++;
                end else begin
                    want = expected_readings.pop_front();
                    if (o_out_data.pulse_accepted !== want.pulse_accepted) begin
                        $error("pulse_accepted: expected %0d, got %0d",
                               want.pulse_accepted, o_out_data.pulse_accepted);
                        mismatch_count++;
                    end
                    if (o_out_data.speed_q8 !== want.speed_q8) begin
                        $error("speed_q8: expected %0d, got %0d",
                               want.speed_q8, o_out_data.speed_q8);
                        mismatch_count++;
                    end
                    if (o_out_data.accel_q8 !== want.accel_q8) begin
                        $error("accel_q8: expected %0d, got %0d",
                               want.accel_q8, o_out_data.accel_q8);
                        mismatch_count++;
                    end
                    if (o_out_data.trip_m !== want.trip_m) begin
                        $error("trip_m: expected %0d, got %0d",
                               want.trip_m, o_out_data.trip_m);
                        mismatch_count++;
                    end
                end
            end
            if (in_taken) begin
                want = predict_reading(i_in_data);
                expected_readings.push_back(use_typed ? typed_reading : want);
            end
            if (out_taken || in_taken) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    initial begin : receiver
        int   mode;
        int   span;
        int   run;
        logic level;
        i_out_stall = 1'b0;
        run = 0;
        level = 1'b0;
        forever begin
            mode = $urandom_range(0, 2);
            span = $urandom_range(20, 300);
            for (int n = 0; n < span; n++) begin
                @(negedge i_clk);
                case (mode)
                    0: begin
                        i_out_stall <= 1'b0;
                    end
                    1: begin
                        i_out_stall <= 1'($urandom_range(0, 1));
                    end
                    default: begin
                        if (run == 0) begin
                            level = !level;
                            run = $urandom_range(1, 40);
                        end
                        i_out_stall <= level;
                        run--;
                    end
                endcase
            end
        end
    end

    task automatic send_item(input logic cmd, input logic [31:0] at_ms);
        i_in_valid <= 1'b1;
        i_in_data  <= '{command: cmd, time_ms: at_ms};
        @(posedge i_clk);
        while (o_in_stall) begin
            @(posedge i_clk);
        end
        @(negedge i_clk);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        @(negedge i_clk);
        while (expected_readings.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    task automatic write_reg(input logic [wps_pkg::CFG_IDX_W-1:0] idx,
                             input logic [wps_pkg::CFG_DATA_W-1:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            wps_pkg::CFG_WHEEL_DIAMETER: wheel_diam = val[7:0];
            wps_pkg::CFG_DEBOUNCE_MS:    debounce_ms = val;
            default: ;
        endcase
        @(negedge i_clk);
    endtask

    function automatic script_row_t row_item(input logic cmd, input logic [31:0] at_ms);
        script_row_t r;
        r = '0;
        r.kind  = ROW_ITEM;
        r.cmd   = cmd;
        r.at_ms = at_ms;
        return r;
    endfunction

    function automatic script_row_t row_cfg(input logic [wps_pkg::CFG_IDX_W-1:0] idx,
                                            input logic [wps_pkg::CFG_DATA_W-1:0] val);
        script_row_t r;
        r = '0;
        r.kind = ROW_CFG;
        r.idx  = idx;
        r.val  = val;
        return r;
    endfunction

    function automatic script_row_t row_check(input logic cmd, input logic [31:0] at_ms,
                                              input logic acc, input logic [17:0] spd,
                                              input logic signed [19:0] accel,
                                              input logic [31:0] trip);
        script_row_t r;
        r = row_item(cmd, at_ms);
        r.checked = 1'b1;
        r.want.pulse_accepted = acc;
        r.want.speed_q8       = spd;
        r.want.accel_q8       = accel;
        r.want.trip_m         = trip;
        return r;
    endfunction

    initial begin : stimulus
        int          sent;
        int          burst;
        int          gap;
        int          r;
        logic [7:0]  diam;
        logic [15:0] deb;
        logic [31:0] cursor;
        logic [31:0] at_ms;
        logic [31:0] kspan;
        logic        cmd;

        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_in_data     = '0;
        i_cfg_we      = 1'b0;
        i_cfg_idx     = '0;
        i_cfg_data    = '0;
        use_typed     = 1'b0;
        typed_reading = '0;

        directed = '{
            row_check(CMD_QUERY, 32'd0, 1'b0, SPEED_TOP, ACCEL_TOP, 32'd0),
            row_item(CMD_PULSE, 32'd50),
            row_item(CMD_PULSE, 32'd99),
            row_item(CMD_PULSE, 32'd100),
            row_item(CMD_PULSE, 32'd150),
            row_item(CMD_PULSE, 32'd1100),
            row_item(CMD_PULSE, 32'd2000),
            row_item(CMD_PULSE, 32'd2700),
            row_item(CMD_PULSE, 32'd4200),
            row_item(CMD_QUERY, 32'd4300),
            row_item(CMD_QUERY, 32'd20000),
            row_cfg(wps_pkg::CFG_DEBOUNCE_MS, 16'd0),
            row_item(CMD_PULSE, 32'd20000),
            row_item(CMD_PULSE, 32'd20000),
            row_cfg(wps_pkg::CFG_WHEEL_DIAMETER, 16'hA5FF),
            row_item(CMD_PULSE, 32'd20100),
            row_item(CMD_PULSE, 32'd20102),
            row_cfg(wps_pkg::CFG_DEBOUNCE_MS, 16'hFFFF),
            row_item(CMD_PULSE, 32'd85636),
            row_item(CMD_PULSE, 32'd85637),
            row_item(CMD_PULSE, 32'hFFFF_FFFF),
            row_item(CMD_PULSE, 32'h0000_FFFE),
            row_item(CMD_QUERY, 32'h0001_0000),
            row_cfg(wps_pkg::CFG_WHEEL_DIAMETER, 16'd0),
            row_check(CMD_PULSE, 32'h0002_0000, 1'b1, 18'd0, 20'sd0, 32'd0),
            row_check(CMD_QUERY, 32'h0002_0000, 1'b0, 18'd0, 20'sd0, 32'd0),
            row_cfg(wps_pkg::CFG_WHEEL_DIAMETER, 16'(wps_pkg::DIAM_RESET)),
            row_cfg(wps_pkg::CFG_DEBOUNCE_MS, wps_pkg::DEB_RESET)
        };

        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (directed[i]) begin
            if (directed[i].kind == ROW_CFG) begin
                drain();
                write_reg(directed[i].idx, directed[i].val);
            end else begin
                use_typed     = directed[i].checked;
                typed_reading = directed[i].want;
                send_item(directed[i].cmd, directed[i].at_ms);
                use_typed = 1'b0;
            end
        end

        cursor = 32'h0003_0000;
        for (int phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0: begin diam = 8'd27;  deb = 16'd100;   end
                1: begin diam = 8'd255; deb = 16'd0;     end
                2: begin diam = 8'd0;   deb = 16'hFFFF;  end
                3: begin diam = 8'd1;   deb = 16'($urandom_range(0, 50)); end
                default: begin
                    diam = 8'($urandom);
                    deb  = 16'($urandom_range(0, 400));
                end
            endcase
            drain();
            write_reg(wps_pkg::CFG_WHEEL_DIAMETER, {8'($urandom), diam});
            write_reg(wps_pkg::CFG_DEBOUNCE_MS, deb);
            kspan = 32'(wheel_diam) * 32'd574 + 32'd20;

            sent = 0;
            while (sent < PHASE_ITEMS) begin
                burst = $urandom_range(1, 16);
                for (int b = 0; b < burst && sent < PHASE_ITEMS; b++) begin
                    // hold off until every outstanding result is back
                    if (phase == 3 && sent == PHASE_ITEMS / 2) begin
                        drain();
                    end
                    r = $urandom_range(0, 99);
                    if (r < 65) begin
                        cmd = CMD_PULSE;
                        cursor = cursor + 32'(debounce_ms) + $urandom_range(0, kspan);
                        at_ms = cursor;
                    end else if (r < 78) begin
                        cmd = CMD_QUERY;
                        at_ms = cursor + $urandom_range(0, 3000);
                    end else if (r < 88) begin
                        cmd = CMD_PULSE;
                        at_ms = cursor + $urandom_range(0, 32'(debounce_ms));
                    end else begin
                        cmd = 1'($urandom_range(0, 1));
                        at_ms = $urandom;
                        if ($urandom_range(0, 1) == 1) begin
                            cursor = at_ms;
                        end
                    end
                    send_item(cmd, at_ms);
                    sent++;
                end
                if ($urandom_range(0, 9) >= 3) begin
                    gap = $urandom_range(1, 30);
                    i_in_valid <= 1'b0;
                    repeat (gap) @(negedge i_clk);
                end
            end
        end

        drain();
        repeat (SETTLE_WAIT) @(negedge i_clk);
        if (mismatch_count == 0 && expected_readings.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

>>> sim.f
rtl/wps_pkg.sv
rtl/wheel_pulse_speedometer.sv
bench/tb.sv
